// ===== hdl/rsbro_pkg.sv =====
// Package with shared constants, types and helper functions for the raster sorter.
`default_nettype none
package rsbro_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;
    localparam int IDX_BITS   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int SHIFT_BITS = $clog2(IDX_BITS + 1);
    localparam int NUM_BITS   = 7;

    typedef struct packed {
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
        logic [IDX_BITS-1:0]   idx;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_PUT,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    // True when stored entry a comes strictly after entry b in raster order.
    function automatic logic key_after(input t_entry a, input t_entry b);
        return {a.y, a.x} > {b.y, b.x};
    endfunction

    function automatic logic [IDX_BITS-1:0] bit_rev(input logic [IDX_BITS-1:0] v);
        logic [IDX_BITS-1:0] r;
        for (int b = 0; b < IDX_BITS; b++) begin
            r[b] = v[IDX_BITS-1-b];
        end
        return r;
    endfunction

    // Number of index bits needed to span cnt entries (log2 of the next power of two).
    function automatic logic [SHIFT_BITS-1:0] span_bits(input logic [CNT_BITS-1:0] cnt);
        logic [SHIFT_BITS-1:0] r;
        r = '0;
        for (int b = 0; b < IDX_BITS; b++) begin
            if ((CNT_BITS+1)'(1 << b) < {1'b0, cnt}) begin
                r = SHIFT_BITS'(b + 1);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/rsbro_if.sv =====
// Handshake channel interfaces for point beats and result beats.
`default_nettype none
interface rsbro_in_if;
    logic                            valid;
    logic                            ready;
    logic [rsbro_pkg::COORD_BITS-1:0] x_coord;
    logic [rsbro_pkg::COORD_BITS-1:0] y_coord;
    logic                            last_point;

    modport source (output valid, x_coord, y_coord, last_point, input ready);
    modport sink   (input valid, x_coord, y_coord, last_point, output ready);
endinterface

interface rsbro_out_if;
    logic                          valid;
    logic                          ready;
    logic [rsbro_pkg::NUM_BITS-1:0] point_number;
    logic                          final_result;
    logic                          overflow;

    modport source (output valid, point_number, final_result, overflow, input ready);
    modport sink   (input valid, point_number, final_result, overflow, output ready);
endinterface
`default_nettype wire

// ===== hdl/raster_sort_bit_reversed_order.sv =====
// Raster-order point sorter with bit-reversed emission of load numbers.
//
// Points arrive as beats on i_pt (x_coord, y_coord, last_point). Each point is
// insertion-sorted into one RAM that holds {y, x, load index} in raster order.
// A point whose insertion position is k below the current count walks down
// k entries, each moved up one slot by one RAM read/compare/write, then is
// written into the freed slot; the first point of a set is written directly.
// i_pt.ready is high only between points. Up to MAX_POINTS (64) points are
// held; later points of a set are dropped and flag overflow on every result.
// A beat with last_point set (stored or dropped) starts emission: sorted
// positions are visited in bit-reversed order over the next power of two of
// the count, and each valid position yields one beat on o_res carrying the
// 1-based load number; final_result marks the set's last beat. Each result
// goes through a RAM read state and then an output register load state;
// skipped indices only pass through the read state. If o_res is stalled,
// emission waits with the result held in the output register. After the
// final result, a new empty set begins. Reset (i_rst_n low, synchronous)
// empties the set and clears overflow; the RAM contents need no clearing.
`default_nettype none
module raster_sort_bit_reversed_order (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rsbro_in_if.sink   i_pt,
    rsbro_out_if.source o_res
);

    rsbro_pkg::t_state r_state, n_state;
    logic [rsbro_pkg::CNT_BITS-1:0]   r_count, n_count;
    logic                             r_ovf, n_ovf;
    rsbro_pkg::t_entry                r_new, n_new;
    logic [rsbro_pkg::IDX_BITS-1:0]   r_pos, n_pos;
    logic                             r_last, n_last;
    logic [rsbro_pkg::IDX_BITS-1:0]   r_scan, n_scan;
    logic [rsbro_pkg::CNT_BITS-1:0]   r_emitted, n_emitted;
    logic                             r_out_valid, n_out_valid;
    logic [rsbro_pkg::NUM_BITS-1:0]   r_out_num, n_out_num;
    logic                             r_out_final, n_out_final;
    logic                             r_out_ovf, n_out_ovf;

    logic                                   ram_we;
    logic [rsbro_pkg::IDX_BITS-1:0]         ram_waddr;
    rsbro_pkg::t_entry                      ram_wdata;
    logic [rsbro_pkg::IDX_BITS-1:0]         ram_raddr;
    logic [rsbro_pkg::ENTRY_BITS-1:0]       ram_rdata;
    rsbro_pkg::t_entry                      rd_entry;

    logic                                   in_fire;
    logic                                   out_fire;
    logic [rsbro_pkg::SHIFT_BITS-1:0]       w_shift;
    logic [rsbro_pkg::IDX_BITS-1:0]         w_rev;
    logic                                   w_final;

    rsbro_ram #(
        .WIDTH (rsbro_pkg::ENTRY_BITS),
        .DEPTH (rsbro_pkg::MAX_POINTS)
    ) u_sort_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = rsbro_pkg::t_entry'(ram_rdata);
    assign in_fire  = i_pt.valid && i_pt.ready;
    assign out_fire = o_res.valid && o_res.ready;

    // Sorted position for the scan index: reverse over all index bits, then
    // drop the bits above the span of the current count.
    assign w_shift = rsbro_pkg::SHIFT_BITS'(rsbro_pkg::IDX_BITS) -
                     rsbro_pkg::span_bits(r_count);
    assign w_rev   = rsbro_pkg::bit_rev(r_scan) >> w_shift;
    assign w_final = (r_emitted + rsbro_pkg::CNT_BITS'(1)) == r_count;

    assign i_pt.ready         = (r_state == rsbro_pkg::ST_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.point_number = r_out_num;
    assign o_res.final_result = r_out_final;
    assign o_res.overflow     = r_out_ovf;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_new       = r_new;
        n_pos       = r_pos;
        n_last      = r_last;
        n_scan      = r_scan;
        n_emitted   = r_emitted;
        n_out_valid = out_fire ? 1'b0 : r_out_valid;
        n_out_num   = r_out_num;
        n_out_final = r_out_final;
        n_out_ovf   = r_out_ovf;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = r_new;
        ram_raddr   = '0;

        case (r_state)
            rsbro_pkg::ST_IDLE: begin
                n_scan    = '0;
                n_emitted = '0;
                if (in_fire) begin
                    if (r_count == rsbro_pkg::CNT_BITS'(rsbro_pkg::MAX_POINTS)) begin
                        n_ovf = 1'b1;
                        if (i_pt.last_point) begin
                            n_state = rsbro_pkg::ST_EMIT_RD;
                        end
                    end else begin
                        n_new.y   = i_pt.y_coord;
                        n_new.x   = i_pt.x_coord;
                        n_new.idx = rsbro_pkg::IDX_BITS'(r_count);
                        n_last    = i_pt.last_point;
                        if (r_count == '0) begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = n_new;
                            n_count   = rsbro_pkg::CNT_BITS'(1);
                            if (i_pt.last_point) begin
                                n_state = rsbro_pkg::ST_EMIT_RD;
                            end
                        end else begin
                            ram_raddr = rsbro_pkg::IDX_BITS'(r_count - rsbro_pkg::CNT_BITS'(1));
                            n_pos     = rsbro_pkg::IDX_BITS'(r_count);
                            n_state   = rsbro_pkg::ST_CMP;
                        end
                    end
                end
            end
            rsbro_pkg::ST_CMP: begin
                ram_we = 1'b1;
                if (rsbro_pkg::key_after(rd_entry, r_new)) begin
                    // Move the larger entry up one slot and look one further down.
                    ram_wdata = rd_entry;
                    n_pos     = r_pos - rsbro_pkg::IDX_BITS'(1);
                    ram_raddr = r_pos - rsbro_pkg::IDX_BITS'(2);
                    if (r_pos == rsbro_pkg::IDX_BITS'(1)) begin
                        n_state = rsbro_pkg::ST_PUT;
                    end
                end else begin
                    n_count = r_count + rsbro_pkg::CNT_BITS'(1);
                    n_state = r_last ? rsbro_pkg::ST_EMIT_RD : rsbro_pkg::ST_IDLE;
                end
            end
            rsbro_pkg::ST_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                n_count   = r_count + rsbro_pkg::CNT_BITS'(1);
                n_state   = r_last ? rsbro_pkg::ST_EMIT_RD : rsbro_pkg::ST_IDLE;
            end
            rsbro_pkg::ST_EMIT_RD: begin
                ram_raddr = w_rev;
                if ({1'b0, w_rev} >= (rsbro_pkg::IDX_BITS+1)'(r_count)) begin
                    n_scan = r_scan + rsbro_pkg::IDX_BITS'(1);
                end else if (!r_out_valid || out_fire) begin
                    n_scan  = r_scan + rsbro_pkg::IDX_BITS'(1);
                    n_state = rsbro_pkg::ST_EMIT_LD;
                end
            end
            rsbro_pkg::ST_EMIT_LD: begin
                n_out_valid = 1'b1;
                n_out_num   = rsbro_pkg::NUM_BITS'(rd_entry.idx) + rsbro_pkg::NUM_BITS'(1);
                n_out_final = w_final;
                n_out_ovf   = r_ovf;
                n_emitted   = r_emitted + rsbro_pkg::CNT_BITS'(1);
                if (w_final) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = rsbro_pkg::ST_IDLE;
                end else begin
                    n_state = rsbro_pkg::ST_EMIT_RD;
                end
            end
            default: begin
                n_state = rsbro_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsbro_pkg::ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new       <= n_new;
        r_pos       <= n_pos;
        r_last      <= n_last;
        r_scan      <= n_scan;
        r_emitted   <= n_emitted;
        r_out_num   <= n_out_num;
        r_out_final <= n_out_final;
        r_out_ovf   <= n_out_ovf;
    end

    // The insertion walk never reaches below slot zero.
    a_cmp_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rsbro_pkg::ST_CMP |-> r_pos != '0)
        else $error("insertion walk at slot zero");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rsbro_pkg::CNT_BITS'(rsbro_pkg::MAX_POINTS))
        else $error("point count beyond capacity");

    // Emission never produces more results than points held.
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsbro_pkg::ST_EMIT_RD || r_state == rsbro_pkg::ST_EMIT_LD)
        |-> r_emitted < r_count)
        else $error("emitted more results than stored points");

    // A final beat leaves the block with an empty set.
    a_final_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) && r_out_final |-> r_count == '0 && !r_ovf)
        else $error("set not cleared after final result");

endmodule
`default_nettype wire

// ===== hdl/rsbro_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module rsbro_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire
